>>> rtl/core/erw_pkg.sv
// shared types, codes and defaults of the escalating recovery watchdog
package erw_pkg;

    // operation codes
    localparam logic [2:0] OP_CHECK     = 3'd0;
    localparam logic [2:0] OP_FEED      = 3'd1;
    localparam logic [2:0] OP_TRIGGER   = 3'd2;
    localparam logic [2:0] OP_SET_EN    = 3'd3;
    localparam logic [2:0] OP_CLR_STATS = 3'd4;

    // recovery levels, also used as action codes
    localparam logic [2:0] LVL_NONE    = 3'd0;
    localparam logic [2:0] LVL_SOFT    = 3'd1;
    localparam logic [2:0] LVL_PERIPH  = 3'd2;
    localparam logic [2:0] LVL_HARD    = 3'd3;
    localparam logic [2:0] LVL_FACTORY = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_WARNING  = 2'd1;
    localparam logic [1:0] REG_HOLD     = 2'd2;
    localparam logic [1:0] REG_MAX_ATT  = 2'd3;

    // configuration defaults
    localparam logic [31:0] TIMEOUT_DEFAULT = 32'd5000;
    localparam logic [31:0] WARNING_DEFAULT = 32'd3000;
    localparam logic [31:0] HOLD_DEFAULT    = 32'd60000;
    localparam logic [5:0]  MAX_ATT_DEFAULT = 6'd3;

    typedef struct packed {
        logic [31:0] timeout_ms;
        logic [31:0] warning_ms;
        logic [31:0] hold_ms;
        logic [5:0]  max_attempts;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ms;
        logic [2:0]  level_request;
        logic        enable_value;
    } item_t;

    typedef struct packed {
        logic [31:0] heartbeat_time;
        logic [31:0] recovery_time;
        logic [7:0]  attempt_count;
        logic [2:0]  recovery_level;
        logic [15:0] total_recoveries;
        logic [15:0] soft_recoveries;
        logic [15:0] hard_recoveries;
        logic        enable_flag;
    } state_t;

    typedef struct packed {
        logic        healthy;
        logic [2:0]  action;
        logic        warning;
        logic [2:0]  level_now;
        logic [7:0]  attempts_now;
        logic [15:0] total_count;
        logic [15:0] soft_count;
        logic [15:0] hard_count;
        logic        enabled_now;
    } result_t;

endpackage

>>> rtl/core/escalating_recovery_watchdog_core.sv
// top level of the escalating recovery watchdog: input register, state, result register
//
//  channel  | direction | handshake          | payload
//  s_       | in        | s_valid / s_ready  | operation, now_ms, level_request, enable_value
//  m_       | out       | m_valid / m_ready  | healthy, action, warning, level_now, attempts_now,
//           |           |                    | total/soft/hard counts, enabled_now
//  cfg_     | in        | cfg_we             | cfg_index, cfg_wdata (no read-back)
//
// one item per cycle sustained while m_ready is held high; an item passes through the input
// register, then the step logic into the result register
// the watchdog state updates in the same cycle an item moves into the result register
// reset restores the configuration defaults and the watchdog state, and empties both stages
// a stalled result holds its register; the input register keeps accepting until it is full
module escalating_recovery_watchdog_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [31:0] s_now_ms,
    input  logic [2:0]  s_level_request,
    input  logic        s_enable_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_healthy,
    output logic [2:0]  m_action,
    output logic        m_warning,
    output logic [2:0]  m_level_now,
    output logic [7:0]  m_attempts_now,
    output logic [15:0] m_total_count,
    output logic [15:0] m_soft_count,
    output logic [15:0] m_hard_count,
    output logic        m_enabled_now
);

    erw_pkg::cfg_t    cfg;
    erw_pkg::item_t   item_reg;
    erw_pkg::item_t   item_next;
    logic             item_valid_reg;
    erw_pkg::state_t  state_reg;
    erw_pkg::state_t  state_next;
    erw_pkg::result_t res_reg;
    erw_pkg::result_t res_next;
    logic             res_valid_reg;
    logic             advance;
    logic             in_xfer;

    erw_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    erw_step u_step (
        .cfg     (cfg),
        .item    (item_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // the held item moves on when the result register is free or being drained
    assign advance = item_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || advance;
    assign in_xfer = s_valid && s_ready;

    always_comb begin
        item_next.operation     = s_operation;
        item_next.now_ms        = s_now_ms;
        item_next.level_request = s_level_request;
        item_next.enable_value  = s_enable_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg.heartbeat_time   <= 32'd0;
            state_reg.recovery_time    <= 32'd0;
            state_reg.attempt_count    <= 8'd0;
            state_reg.recovery_level   <= erw_pkg::LVL_NONE;
            state_reg.total_recoveries <= 16'd0;
            state_reg.soft_recoveries  <= 16'd0;
            state_reg.hard_recoveries  <= 16'd0;
            state_reg.enable_flag      <= 1'b1;
        end else begin
            if (in_xfer) begin
                item_valid_reg <= 1'b1;
            end else if (advance) begin
                item_valid_reg <= 1'b0;
            end
            if (advance) begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            item_reg <= item_next;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = res_valid_reg;
    assign m_healthy      = res_reg.healthy;
    assign m_action       = res_reg.action;
    assign m_warning      = res_reg.warning;
    assign m_level_now    = res_reg.level_now;
    assign m_attempts_now = res_reg.attempts_now;
    assign m_total_count  = res_reg.total_count;
    assign m_soft_count   = res_reg.soft_count;
    assign m_hard_count   = res_reg.hard_count;
    assign m_enabled_now  = res_reg.enabled_now;

endmodule

>>> rtl/core/erw_cfg_regs.sv
// configuration register file of the watchdog
module erw_cfg_regs (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_wdata,
    output erw_pkg::cfg_t  cfg
);

    erw_pkg::cfg_t cfg_reg;
    erw_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                erw_pkg::REG_TIMEOUT: cfg_next.timeout_ms   = cfg_wdata;
                erw_pkg::REG_WARNING: cfg_next.warning_ms   = cfg_wdata;
                erw_pkg::REG_HOLD:    cfg_next.hold_ms      = cfg_wdata;
                erw_pkg::REG_MAX_ATT: cfg_next.max_attempts = cfg_wdata[5:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ms   <= erw_pkg::TIMEOUT_DEFAULT;
            cfg_reg.warning_ms   <= erw_pkg::WARNING_DEFAULT;
            cfg_reg.hold_ms      <= erw_pkg::HOLD_DEFAULT;
            cfg_reg.max_attempts <= erw_pkg::MAX_ATT_DEFAULT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/erw_step.sv
// per-item next state and result logic of the watchdog
module erw_step (
    input  erw_pkg::cfg_t    cfg,
    input  erw_pkg::item_t   item,
    input  erw_pkg::state_t  st,
    output erw_pkg::state_t  st_next,
    output erw_pkg::result_t res
);

    logic [31:0] age;
    logic [31:0] since_recovery;
    logic        is_check;
    logic        timed_out;
    logic        recover;
    logic [2:0]  req_level;
    logic [2:0]  esc_level;
    logic [2:0]  sel_level;
    logic [2:0]  mid_level;
    logic        sel_soft;
    logic        sel_hard;
    logic        feed_do;
    logic        feed_clear;
    logic [8:0]  thr1;
    logic [8:0]  thr2;
    logic [8:0]  thr3;
    logic [8:0]  att_ext;
    logic [7:0]  att_mid;

    assign age            = item.now_ms - st.heartbeat_time;
    assign since_recovery = item.now_ms - st.recovery_time;
    assign is_check       = (item.operation == erw_pkg::OP_CHECK) && st.enable_flag;
    assign timed_out      = age > cfg.timeout_ms;

    assign thr1    = {3'd0, cfg.max_attempts};
    assign thr2    = {2'd0, cfg.max_attempts, 1'b0};
    assign thr3    = thr1 + thr2;
    assign att_ext = {1'b0, st.attempt_count};

    always_comb begin
        esc_level = st.recovery_level;
        case (st.recovery_level)
            erw_pkg::LVL_NONE:   esc_level = erw_pkg::LVL_SOFT;
            erw_pkg::LVL_SOFT:   if (att_ext >= thr1) esc_level = erw_pkg::LVL_PERIPH;
            erw_pkg::LVL_PERIPH: if (att_ext >= thr2) esc_level = erw_pkg::LVL_HARD;
            erw_pkg::LVL_HARD:   if (att_ext >= thr3) esc_level = erw_pkg::LVL_FACTORY;
            default:             esc_level = st.recovery_level;
        endcase
    end

    // out-of-range manual levels act as none
    assign req_level = (item.level_request <= erw_pkg::LVL_FACTORY) ?
                       item.level_request : erw_pkg::LVL_NONE;

    assign recover   = (is_check && timed_out) || (item.operation == erw_pkg::OP_TRIGGER);
    assign sel_level = (item.operation == erw_pkg::OP_TRIGGER) ? req_level : esc_level;
    assign sel_soft  = sel_level inside {erw_pkg::LVL_SOFT, erw_pkg::LVL_PERIPH};
    assign sel_hard  = sel_level inside {erw_pkg::LVL_HARD, erw_pkg::LVL_FACTORY};
    assign mid_level = recover ? sel_level : st.recovery_level;

    // soft-side recoveries refeed, which may drop the escalation
    assign feed_do = ((item.operation == erw_pkg::OP_FEED) && st.enable_flag) ||
                     ((item.operation == erw_pkg::OP_SET_EN) && item.enable_value) ||
                     (recover && sel_soft && st.enable_flag);
    assign feed_clear = feed_do && (mid_level != erw_pkg::LVL_NONE) &&
                        (since_recovery > cfg.hold_ms);

    assign att_mid = feed_clear ? 8'd0 : st.attempt_count;

    always_comb begin
        st_next = st;
        if (feed_do) begin
            st_next.heartbeat_time = item.now_ms;
        end
        st_next.recovery_level = feed_clear ? erw_pkg::LVL_NONE : mid_level;
        st_next.attempt_count  = att_mid;
        if (recover) begin
            st_next.recovery_time = item.now_ms;
            if (att_mid != 8'hFF) begin
                st_next.attempt_count = att_mid + 8'd1;
            end
        end
        if (recover && (item.operation == erw_pkg::OP_CHECK) &&
            (st.total_recoveries != 16'hFFFF)) begin
            st_next.total_recoveries = st.total_recoveries + 16'd1;
        end
        if (recover && sel_soft && (st.soft_recoveries != 16'hFFFF)) begin
            st_next.soft_recoveries = st.soft_recoveries + 16'd1;
        end
        if (recover && sel_hard && (st.hard_recoveries != 16'hFFFF)) begin
            st_next.hard_recoveries = st.hard_recoveries + 16'd1;
        end
        if (item.operation == erw_pkg::OP_SET_EN) begin
            st_next.enable_flag = item.enable_value;
        end
        if (item.operation == erw_pkg::OP_CLR_STATS) begin
            st_next.total_recoveries = 16'd0;
            st_next.soft_recoveries  = 16'd0;
            st_next.hard_recoveries  = 16'd0;
            st_next.attempt_count    = 8'd0;
            st_next.recovery_level   = erw_pkg::LVL_NONE;
        end
    end

    always_comb begin
        res.healthy      = !(is_check && timed_out);
        res.action       = recover ? sel_level : erw_pkg::LVL_NONE;
        res.warning      = is_check && !timed_out && (age > cfg.warning_ms);
        res.level_now    = st_next.recovery_level;
        res.attempts_now = st_next.attempt_count;
        res.total_count  = st_next.total_recoveries;
        res.soft_count   = st_next.soft_recoveries;
        res.hard_count   = st_next.hard_recoveries;
        res.enabled_now  = st_next.enable_flag;
    end

endmodule

>>> tb/tb_escalating_recovery_watchdog_core.sv
// testbench for the escalating recovery watchdog core: directed and random items, scoreboard
module tb_escalating_recovery_watchdog_core;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD = 60;
    localparam int DRAIN_CYCLES = 8;

    class recovery_tracker;
        erw_pkg::cfg_t    cfg;
        erw_pkg::state_t  wd;
        erw_pkg::result_t pending_reports[$];
        int               fails;

        function new();
            cfg.timeout_ms   = erw_pkg::TIMEOUT_DEFAULT;
            cfg.warning_ms   = erw_pkg::WARNING_DEFAULT;
            cfg.hold_ms      = erw_pkg::HOLD_DEFAULT;
            cfg.max_attempts = erw_pkg::MAX_ATT_DEFAULT;
            wd = '0;
            wd.recovery_level = erw_pkg::LVL_NONE;
            wd.enable_flag = 1'b1;
            fails = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                erw_pkg::REG_TIMEOUT: cfg.timeout_ms = data;
                erw_pkg::REG_WARNING: cfg.warning_ms = data;
                erw_pkg::REG_HOLD:    cfg.hold_ms = data;
                erw_pkg::REG_MAX_ATT: cfg.max_attempts = data[5:0];
                default: ;
            endcase
        endfunction

        // heartbeat refresh; clears escalation once the hold time has passed
        function void refeed(logic [31:0] now_ms);
            logic [31:0] since_rec;
            if (!wd.enable_flag) return;
            wd.heartbeat_time = now_ms;
            since_rec = now_ms - wd.recovery_time;
            if (wd.recovery_level != erw_pkg::LVL_NONE && since_rec > cfg.hold_ms) begin
                wd.recovery_level = erw_pkg::LVL_NONE;
                wd.attempt_count = '0;
            end
        endfunction

        function logic [2:0] apply_reset(logic [2:0] level, logic [31:0] now_ms);
            if (level == erw_pkg::LVL_SOFT || level == erw_pkg::LVL_PERIPH) begin
                if (wd.soft_recoveries != 16'hFFFF) wd.soft_recoveries++;
                refeed(now_ms);
                return level;
            end
            if (level == erw_pkg::LVL_HARD || level == erw_pkg::LVL_FACTORY) begin
                if (wd.hard_recoveries != 16'hFFFF) wd.hard_recoveries++;
                return level;
            end
            return erw_pkg::LVL_NONE;
        endfunction

        function void step_up();
            int unsigned m;
            m = cfg.max_attempts;
            case (wd.recovery_level)
                erw_pkg::LVL_NONE: wd.recovery_level = erw_pkg::LVL_SOFT;
                erw_pkg::LVL_SOFT: begin
                    if (wd.attempt_count >= m) wd.recovery_level = erw_pkg::LVL_PERIPH;
                end
                erw_pkg::LVL_PERIPH: begin
                    if (wd.attempt_count >= m * 2) wd.recovery_level = erw_pkg::LVL_HARD;
                end
                erw_pkg::LVL_HARD: begin
                    if (wd.attempt_count >= m * 3) wd.recovery_level = erw_pkg::LVL_FACTORY;
                end
                default: ;
            endcase
        endfunction

        // advance the watchdog by one accepted item and queue the report it produces
        function void note_item(erw_pkg::item_t it);
            erw_pkg::result_t r;
            logic [31:0]      age;
            r = '0;
            r.healthy = 1'b1;
            r.action = erw_pkg::LVL_NONE;
            case (it.operation)
                erw_pkg::OP_CHECK: begin
                    if (wd.enable_flag) begin
                        age = it.now_ms - wd.heartbeat_time;
                        if (age > cfg.timeout_ms) begin
                            step_up();
                            r.action = apply_reset(wd.recovery_level, it.now_ms);
                            wd.recovery_time = it.now_ms;
                            if (wd.attempt_count != 8'hFF) wd.attempt_count++;
                            if (wd.total_recoveries != 16'hFFFF) wd.total_recoveries++;
                            r.healthy = 1'b0;
                        end else if (age > cfg.warning_ms) begin
                            r.warning = 1'b1;
                        end
                    end
                end
                erw_pkg::OP_FEED: refeed(it.now_ms);
                erw_pkg::OP_TRIGGER: begin
                    wd.recovery_level = (it.level_request <= erw_pkg::LVL_FACTORY) ?
                                        it.level_request : erw_pkg::LVL_NONE;
                    r.action = apply_reset(wd.recovery_level, it.now_ms);
                    wd.recovery_time = it.now_ms;
                    if (wd.attempt_count != 8'hFF) wd.attempt_count++;
                end
                erw_pkg::OP_SET_EN: begin
                    wd.enable_flag = it.enable_value;
                    if (it.enable_value) refeed(it.now_ms);
                end
                erw_pkg::OP_CLR_STATS: begin
                    wd.total_recoveries = '0;
                    wd.soft_recoveries = '0;
                    wd.hard_recoveries = '0;
                    wd.attempt_count = '0;
                    wd.recovery_level = erw_pkg::LVL_NONE;
                end
                default: ;
            endcase
            r.level_now    = wd.recovery_level;
            r.attempts_now = wd.attempt_count;
            r.total_count  = wd.total_recoveries;
            r.soft_count   = wd.soft_recoveries;
            r.hard_count   = wd.hard_recoveries;
            r.enabled_now  = wd.enable_flag;
            pending_reports.push_back(r);
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                fails++;
            end
        endfunction

        function void check_report(erw_pkg::result_t got);
            erw_pkg::result_t want;
            if (pending_reports.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, got);
                fails++;
                return;
            end
            want = pending_reports.pop_front();
            match_field("healthy", want.healthy, got.healthy);
            match_field("action", want.action, got.action);
            match_field("warning", want.warning, got.warning);
            match_field("level_now", want.level_now, got.level_now);
            match_field("attempts_now", want.attempts_now, got.attempts_now);
            match_field("total_count", want.total_count, got.total_count);
            match_field("soft_count", want.soft_count, got.soft_count);
            match_field("hard_count", want.hard_count, got.hard_count);
            match_field("enabled_now", want.enabled_now, got.enabled_now);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_operation;
    logic [31:0] s_now_ms;
    logic [2:0]  s_level_request;
    logic        s_enable_value;
    logic        m_valid;
    logic        m_ready;
    logic        m_healthy;
    logic [2:0]  m_action;
    logic        m_warning;
    logic [2:0]  m_level_now;
    logic [7:0]  m_attempts_now;
    logic [15:0] m_total_count;
    logic [15:0] m_soft_count;
    logic [15:0] m_hard_count;
    logic        m_enabled_now;

    recovery_tracker trk;
    logic [31:0]     clock_ms;
    int unsigned     cycles = 0;
    int              reports_seen = 0;
    bit              sender_calm = 0;
    bit              sink_calm = 0;

    escalating_recovery_watchdog_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_now_ms        (s_now_ms),
        .s_level_request (s_level_request),
        .s_enable_value  (s_enable_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_healthy       (m_healthy),
        .m_action        (m_action),
        .m_warning       (m_warning),
        .m_level_now     (m_level_now),
        .m_attempts_now  (m_attempts_now),
        .m_total_count   (m_total_count),
        .m_soft_count    (m_soft_count),
        .m_hard_count    (m_hard_count),
        .m_enabled_now   (m_enabled_now)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL escalating_recovery_watchdog_core");
            $finish;
        end
    end

    function automatic erw_pkg::item_t mk_item(logic [2:0] op, logic [31:0] now_ms,
                                               logic [2:0] req, logic en);
        erw_pkg::item_t it;
        it.operation = op;
        it.now_ms = now_ms;
        it.level_request = req;
        it.enable_value = en;
        return it;
    endfunction

    function automatic erw_pkg::cfg_t mk_cfg(logic [31:0] t, logic [31:0] w, logic [31:0] h,
                                             logic [5:0] m);
        erw_pkg::cfg_t c;
        c.timeout_ms = t;
        c.warning_ms = w;
        c.hold_ms = h;
        c.max_attempts = m;
        return c;
    endfunction

    // one below, at, or one above a threshold, wrapping
    function automatic logic [31:0] near(logic [31:0] t);
        return t + 32'($urandom_range(0, 2)) - 32'd1;
    endfunction

    // time steps are drawn around the configured thresholds so ages land on every band
    function automatic erw_pkg::item_t pick_item(bit grind);
        logic [31:0]     delta;
        longint unsigned span;
        int              r;
        logic [2:0]      op;
        span = longint'(trk.cfg.timeout_ms) + 1;
        case ($urandom_range(0, 9))
            0: delta = '0;
            1: delta = $urandom_range(1, 8);
            2: delta = near(trk.cfg.warning_ms);
            3, 4: delta = near(trk.cfg.timeout_ms);
            5: delta = trk.cfg.timeout_ms + 32'($urandom_range(0, 64));
            6: delta = near(trk.cfg.hold_ms);
            7: delta = $urandom;
            default: delta = 32'(longint'($urandom) % span);
        endcase
        clock_ms = clock_ms + delta;
        r = $urandom_range(0, 99);
        if (grind) begin
            op = (r < 55) ? erw_pkg::OP_CHECK :
                 (r < 90) ? erw_pkg::OP_TRIGGER : erw_pkg::OP_FEED;
        end else if (r < 45 || r >= 95) begin
            op = erw_pkg::OP_CHECK;
        end else if (r < 65) begin
            op = erw_pkg::OP_FEED;
        end else if (r < 75) begin
            op = erw_pkg::OP_TRIGGER;
        end else if (r < 85) begin
            op = erw_pkg::OP_SET_EN;
        end else if (r < 90) begin
            op = erw_pkg::OP_CLR_STATS;
        end else begin
            op = 3'($urandom_range(5, 7));
        end
        // mostly enable so disabled stretches stay short
        return mk_item(op, clock_ms, 3'($urandom_range(0, 7)),
                       (op == erw_pkg::OP_SET_EN) ? ($urandom_range(0, 3) != 0)
                                                  : 1'($urandom));
    endfunction

    task automatic offer(erw_pkg::item_t it);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= it.operation;
        s_now_ms        <= it.now_ms;
        s_level_request <= it.level_request;
        s_enable_value  <= it.enable_value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        trk.note_item(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (trk.pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic write_config(erw_pkg::cfg_t c, logic [25:0] junk);
        logic [31:0] data[4];
        data[0] = c.timeout_ms;
        data[1] = c.warning_ms;
        data[2] = c.hold_ms;
        data[3] = {junk, c.max_attempts};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_wdata <= data[i];
            @(posedge aclk);
            trk.write_reg(2'(i), data[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int n, bit grind);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
            offer(pick_item(grind));
        end
    endtask

    task automatic run_phase(erw_pkg::cfg_t c, logic [25:0] junk, int n, bit grind);
        drain();
        write_config(c, junk);
        run_random(n, grind);
    endtask

    // result side: random stalls, one long hold-off once the stream is busy
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (reports_seen % 50 == 0) sink_calm = ($urandom_range(0, 3) == 0);
            gap = sink_calm ? 0 : $urandom_range(0, 6);
            if (reports_seen == 500) gap = LONG_HOLD;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            trk.check_report({m_healthy, m_action, m_warning, m_level_now, m_attempts_now,
                              m_total_count, m_soft_count, m_hard_count, m_enabled_now});
            reports_seen++;
        end
    end

    initial begin
        erw_pkg::item_t script[$];
        trk = new();
        aresetn         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= erw_pkg::REG_TIMEOUT;
        cfg_wdata       <= '0;
        s_valid         <= 1'b0;
        s_operation     <= erw_pkg::OP_CHECK;
        s_now_ms        <= '0;
        s_level_request <= erw_pkg::LVL_NONE;
        s_enable_value  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // age bands at the default thresholds, then a timeout across the time wrap
        script.push_back(mk_item(erw_pkg::OP_CHECK, 32'd0, erw_pkg::LVL_NONE, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_CHECK, 32'd3000, erw_pkg::LVL_NONE, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_CHECK, 32'd3001, erw_pkg::LVL_NONE, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_CHECK, 32'd5000, erw_pkg::LVL_NONE, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_CHECK, 32'd5001, erw_pkg::LVL_NONE, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_FEED, 32'd5002, erw_pkg::LVL_NONE, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_CHECK, 32'hFFFF_FFFF, erw_pkg::LVL_NONE, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_CHECK, 32'd5000, erw_pkg::LVL_NONE, 1'b0));
        // every manual level but soft, out of range levels act as none
        script.push_back(mk_item(erw_pkg::OP_TRIGGER, 32'd100, erw_pkg::LVL_PERIPH, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_TRIGGER, 32'd200, erw_pkg::LVL_HARD, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_TRIGGER, 32'd300, erw_pkg::LVL_FACTORY, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_TRIGGER, 32'd400, 3'd7, 1'b1));
        script.push_back(mk_item(erw_pkg::OP_TRIGGER, 32'd500, erw_pkg::LVL_NONE, 1'b0));
        // disabled: check and feed do nothing, trigger still acts without refeed
        script.push_back(mk_item(erw_pkg::OP_SET_EN, 32'd600, erw_pkg::LVL_NONE, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_CHECK, 32'h8000_0000, erw_pkg::LVL_NONE, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_FEED, 32'h8000_0001, erw_pkg::LVL_NONE, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_TRIGGER, 32'd700, erw_pkg::LVL_SOFT, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_SET_EN, 32'd800, erw_pkg::LVL_NONE, 1'b1));
        // feed past the hold time clears the escalation
        script.push_back(mk_item(erw_pkg::OP_FEED, 32'd60701, erw_pkg::LVL_NONE, 1'b0));
        script.push_back(mk_item(3'd5, 32'hFFFF_FFFF, 3'd7, 1'b1));
        script.push_back(mk_item(3'd6, 32'hFFFF_FFFF, 3'd7, 1'b1));
        script.push_back(mk_item(3'd7, 32'hFFFF_FFFF, 3'd7, 1'b1));
        script.push_back(mk_item(erw_pkg::OP_CLR_STATS, 32'd0, erw_pkg::LVL_NONE, 1'b0));
        script.push_back(mk_item(erw_pkg::OP_CHECK, 32'h4000_0000, erw_pkg::LVL_NONE, 1'b0));
        foreach (script[i]) offer(script[i]);
        clock_ms = 32'h4000_0000;

        run_random(120, 1'b0);
        run_phase(mk_cfg(32'd100, 32'd40, 32'd1000, 6'd2), '0, 150, 1'b0);
        run_phase(mk_cfg(32'd0, 32'd0, 32'd0, 6'd0), '0, 100, 1'b0);
        run_phase(mk_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63), '0, 80, 1'b0);
        // never clears, so the attempt count climbs to factory and saturates
        run_phase(mk_cfg(32'd1, 32'd0, 32'hFFFF_FFFF, 6'd63), '0, 400, 1'b1);
        run_phase(mk_cfg(32'd20, 32'd30, 32'd200, 6'd1), '0, 150, 1'b0);
        run_phase(mk_cfg($urandom_range(1, 3000), $urandom_range(0, 3000),
                         $urandom_range(0, 20000), 6'($urandom_range(0, 63))),
                  26'($urandom), 200, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (trk.fails == 0) begin
            $display("PASS escalating_recovery_watchdog_core");
        end else begin
            $display("FAIL escalating_recovery_watchdog_core");
        end
        $finish;
    end

endmodule
